@@ rtl/i2cbm_pkg.sv @@
// i2cbm_pkg: beat types and command codes for the i2c byte master core
// no dependencies; imported by i2cbm_seq and i2c_byte_master_core
package i2cbm_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_STOP  = 2'd3;

    localparam int unsigned BYTE_BITS = 8;

    typedef struct packed {
        logic [1:0] func;
        logic       with_start;
        logic       restart;
        logic       with_stop;
        logic [7:0] tx_byte;
        logic       nack_out;
        logic       sda_in;
    } in_beat_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_ok;
        logic       cmd_rejected;
    } out_beat_t;

endpackage

@@ rtl/i2cbm_seq.sv @@
// i2cbm_seq: pin sequencer for start, eight data bits, ack bit and stop
// depends on i2cbm_pkg; advances one delay step per accepted tick beat
module i2cbm_seq
    import i2cbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_beat_t  beat,
    output out_beat_t result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_SR1, PH_SR2, PH_S1, PH_WSET0, PH_WSET, PH_WHI,
        PH_AREL, PH_AHI, PH_ASMP, PH_RSET0, PH_RHI, PH_RSMP,
        PH_NHI, PH_NEND, PH_P0, PH_PHI, PH_PREL
    } phase_t;

    localparam int unsigned PEND_STOP = 0;
    localparam int unsigned PEND_READ = 1;
    localparam int unsigned PEND_NACK = 2;
    localparam logic [3:0]  LAST_BIT  = 4'(BYTE_BITS);

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] pending_reg, pending_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_reg, ack_next;
    logic       done;
    logic       rejected;
    logic [3:0] count_inc;

    assign count_inc = bit_count_reg + 4'd1;

    always_comb begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        pending_next   = pending_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        done           = 1'b0;
        rejected       = 1'b0;
        if (step) begin
            if (beat.func != FUNC_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    case (beat.func)
                        FUNC_WRITE: begin
                            pending_next   = {2'b00, beat.with_stop};
                            shift_next     = beat.tx_byte;
                            bit_count_next = '0;
                            ack_next       = 1'b0;
                            if (beat.with_start) begin
                                phase_next = beat.restart ? PH_SR1 : PH_S1;
                            end else begin
                                phase_next = PH_WSET0;
                            end
                        end
                        FUNC_READ: begin
                            pending_next   = {beat.nack_out, 1'b1, beat.with_stop};
                            shift_next     = '0;
                            bit_count_next = '0;
                            ack_next       = 1'b0;
                            phase_next     = PH_RSET0;
                        end
                        default: begin
                            pending_next = '0;
                            ack_next     = 1'b0;
                            phase_next   = PH_P0;
                        end
                    endcase
                end
            end else begin
                case (phase_reg)
                    PH_SR1: begin
                        sda_next   = 1'b1;
                        phase_next = PH_SR2;
                    end
                    PH_SR2: begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PH_WSET;
                    end
                    PH_S1: begin
                        sda_next   = 1'b0;
                        phase_next = PH_WSET;
                    end
                    PH_WSET0: begin
                        sda_next   = shift_reg[7];
                        phase_next = PH_WHI;
                    end
                    PH_WSET: begin
                        scl_next   = 1'b0;
                        sda_next   = shift_reg[7];
                        phase_next = PH_WHI;
                    end
                    PH_WHI: begin
                        scl_next       = 1'b1;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_count_next = count_inc;
                        phase_next     = (count_inc >= LAST_BIT) ? PH_AREL : PH_WSET;
                    end
                    PH_AREL: begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_AHI;
                    end
                    PH_AHI: begin
                        scl_next   = 1'b1;
                        phase_next = PH_ASMP;
                    end
                    PH_ASMP: begin
                        ack_next = ~beat.sda_in;
                        scl_next = 1'b0;
                        if (pending_reg[PEND_STOP]) begin
                            sda_next   = 1'b0;
                            phase_next = PH_PHI;
                        end else begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_RSET0: begin
                        sda_next   = 1'b1;
                        phase_next = PH_RHI;
                    end
                    PH_RHI: begin
                        scl_next   = 1'b1;
                        phase_next = PH_RSMP;
                    end
                    PH_RSMP: begin
                        shift_next     = {shift_reg[6:0], beat.sda_in};
                        scl_next       = 1'b0;
                        bit_count_next = count_inc;
                        if (count_inc >= LAST_BIT) begin
                            sda_next   = pending_reg[PEND_NACK];
                            phase_next = PH_NHI;
                        end else begin
                            sda_next   = 1'b1;
                            phase_next = PH_RHI;
                        end
                    end
                    PH_NHI: begin
                        scl_next   = 1'b1;
                        phase_next = PH_NEND;
                    end
                    PH_NEND: begin
                        scl_next = 1'b0;
                        if (pending_reg[PEND_STOP]) begin
                            sda_next   = 1'b0;
                            phase_next = PH_PHI;
                        end else begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_P0: begin
                        sda_next   = 1'b0;
                        phase_next = PH_PHI;
                    end
                    PH_PHI: begin
                        scl_next   = 1'b1;
                        phase_next = PH_PREL;
                    end
                    PH_PREL: begin
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        result.scl_out      = scl_next;
        result.sda_out      = sda_next;
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done;
        result.rx_byte      = (done && pending_next[PEND_READ]) ? shift_next : 8'h00;
        result.ack_ok       = done && !pending_next[PEND_READ] && ack_next;
        result.cmd_rejected = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            pending_reg   <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            pending_reg   <= pending_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
        end
    end

    // a rejected command must leave the sequence untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.cmd_rejected) |=> $stable(phase_reg) && $stable(bit_count_reg))
        else $error("rejected command disturbed the sequencer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.done_res) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after done");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && beat.func == FUNC_READ && phase_reg == PH_IDLE)
        |=> (phase_reg == PH_RSET0) && (bit_count_reg == 4'd0) && pending_reg[PEND_READ])
        else $error("read command not loaded");

endmodule

@@ rtl/i2c_byte_master_core.sv @@
// i2c_byte_master_core: top level, sequencer plus output register and skid stage
// depends on i2cbm_pkg and i2cbm_seq
//
// Usage: every beat on the s_ channel is either a command (write byte, read
// byte, stop only) or a tick that advances the SCL/SDA pin sequence by one
// delay step. Commands only load the sequencer while it is idle; a command
// that arrives while busy comes back with cmd_rejected set. Each accepted
// beat produces exactly one beat on the m_ channel carrying the pin levels,
// busy, done and, with done, the received byte or the slave acknowledge.
// A beat's result is registered in the output stage, or in the skid stage if
// the receiver stalls. Throughput: one beat per cycle while s_ready is high;
// the sequencer step is a single pass of logic from the input beat and the
// state registers to the result register. The skid stage lets one more beat
// in while m_ stalls; s_ready drops only when both stages hold a result.
// Reset (aresetn low, synchronous): sequencer idle with SCL and SDA released,
// both result stages empty.
module i2c_byte_master_core
    import i2cbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    out_beat_t step_result;
    out_beat_t out_reg;
    out_beat_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      accept;
    logic      pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    i2cbm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .beat    (s_data),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= step_result;
            end
        end else if (accept) begin
            skid_reg <= step_result;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output stage empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_valid_reg && !m_ready) |=> skid_valid_reg && !s_ready)
        else $error("stalled beat not parked in skid stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> out_valid_reg && !skid_valid_reg)
        else $error("skid beat not moved to output stage");

endmodule
